// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spl assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spl assertion failed");

`endif

// ===== src/spl_pkg.sv =====
package spl_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FREQ_W = 24;
  localparam int TAG_W  = 9;
  localparam int OCC_W  = 7;

  typedef enum logic [1:0] {
    KIND_SORTED = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_POP    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              sorted;
    logic              append;
    logic              pop;
    logic [FREQ_W-1:0] new_freq;
    logic [TAG_W-1:0]  new_tag;
    logic [CNT_W-1:0]  count;
  } spl_cmd_t;

endpackage

// ===== src/spl_cell.sv =====
module spl_cell
  import spl_pkg::*;
(
  input  logic              clk,
  input  spl_cmd_t          cmd,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic              lower_gt,
  input  logic [FREQ_W-1:0] lower_freq,
  input  logic [TAG_W-1:0]  lower_tag,
  input  logic              upper_run,
  input  logic [FREQ_W-1:0] upper_freq,
  input  logic [TAG_W-1:0]  upper_tag,
  output logic [FREQ_W-1:0] freq,
  output logic [TAG_W-1:0]  tag,
  output logic              run,
  output logic              gt
);

  logic [FREQ_W-1:0] freq_r;
  logic [FREQ_W-1:0] freq_nxt;
  logic [TAG_W-1:0]  tag_r;
  logic [TAG_W-1:0]  tag_nxt;
  logic              occ;
  logic              at_count;

  assign occ      = CNT_W'(cell_idx) < cmd.count;
  assign at_count = CNT_W'(cell_idx) == cmd.count;
  // stay in the larger run only while every occupied cell above is larger too
  assign run      = (!occ || (freq_r > cmd.new_freq)) && upper_run;
  assign gt       = occ && run;

  always_comb begin
    freq_nxt = freq_r;
    tag_nxt  = tag_r;
    priority if (cmd.sorted) begin
      if (lower_gt) begin
        freq_nxt = lower_freq;
        tag_nxt  = lower_tag;
      end else if (gt || at_count) begin
        freq_nxt = cmd.new_freq;
        tag_nxt  = cmd.new_tag;
      end
    end else if (cmd.append) begin
      freq_nxt = lower_freq;
      tag_nxt  = lower_tag;
    end else if (cmd.pop) begin
      freq_nxt = upper_freq;
      tag_nxt  = upper_tag;
    end else begin
      freq_nxt = freq_r;
      tag_nxt  = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    freq_r <= freq_nxt;
    tag_r  <= tag_nxt;
  end

  assign freq = freq_r;
  assign tag  = tag_r;

endmodule

// ===== src/sorted_priority_list_core.sv =====
// Sorted priority list of (frequency, tag) entries for code tree building.
// Input channel (in_valid/in_ready) carries one request: kind 0 sorted
// insert, kind 1 append, kind 2 pop of the smallest (tail) entry, kind 3
// no operation. Result channel (out_valid/out_ready) returns one result per
// request: popped entry, occupancy, empty flag and status.
// The list lives in a row of DEPTH cells, tail in cell 0; every cell compares
// its frequency with the new one in parallel and shifts, loads or holds in
// the same cycle. The result is registered at the accept edge and shows in
// the next cycle. Throughput: one request per cycle; in_ready stays high
// while the output register is empty or being drained in the same cycle.
// If the receiver stalls, the result holds and in_ready drops until taken.
// Reset (rst_n low, synchronous) empties the list and the output register;
// no clearing pass is needed, entries beyond the count are never returned.
module sorted_priority_list_core
  import spl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [FREQ_W-1:0] in_new_freq,
  input  logic [TAG_W-1:0]  in_new_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_item_valid,
  output logic [FREQ_W-1:0] out_freq,
  output logic [TAG_W-1:0]  out_tag,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_is_empty,
  output logic [1:0]        out_status
);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              item_valid_r;
  logic [FREQ_W-1:0] freq_r;
  logic [TAG_W-1:0]  tag_r;
  logic [OCC_W-1:0]  occ_r;
  logic              empty_r;
  status_t           status_r;

  logic              accept;
  logic              full;
  logic              empty;
  spl_cmd_t          cmd;
  status_t           status;
  logic              pop_ok;

  logic [FREQ_W-1:0] cell_freq [DEPTH];
  logic [TAG_W-1:0]  cell_tag  [DEPTH];
  logic              cell_gt   [DEPTH];
  logic              cell_run  [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = count_r >= CNT_W'(DEPTH);
  assign empty    = count_r == '0;

  always_comb begin
    cmd          = '0;
    cmd.new_freq = in_new_freq;
    cmd.new_tag  = in_new_tag;
    cmd.count    = count_r;
    status       = ST_OK;
    count_nxt    = count_r;
    pop_ok       = 1'b0;
    unique case (in_kind)
      KIND_SORTED, KIND_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.sorted = accept && (in_kind == KIND_SORTED);
          cmd.append = accept && (in_kind == KIND_APPEND);
          count_nxt  = count_r + 1'b1;
        end
      end
      KIND_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          cmd.pop   = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic              lo_gt;
    logic [FREQ_W-1:0] lo_freq;
    logic [TAG_W-1:0]  lo_tag;
    logic              up_run;
    logic [FREQ_W-1:0] up_freq;
    logic [TAG_W-1:0]  up_tag;

    if (g == 0) begin : g_bottom
      assign lo_gt   = 1'b0;
      assign lo_freq = in_new_freq;
      assign lo_tag  = in_new_tag;
    end else begin : g_mid_lo
      assign lo_gt   = cell_gt[g-1];
      assign lo_freq = cell_freq[g-1];
      assign lo_tag  = cell_tag[g-1];
    end

    if (g == DEPTH - 1) begin : g_top
      assign up_run  = 1'b1;
      assign up_freq = cell_freq[g];
      assign up_tag  = cell_tag[g];
    end else begin : g_mid_up
      assign up_run  = cell_run[g+1];
      assign up_freq = cell_freq[g+1];
      assign up_tag  = cell_tag[g+1];
    end

    spl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(g)),
      .lower_gt   (lo_gt),
      .lower_freq (lo_freq),
      .lower_tag  (lo_tag),
      .upper_run  (up_run),
      .upper_freq (up_freq),
      .upper_tag  (up_tag),
      .freq       (cell_freq[g]),
      .tag        (cell_tag[g]),
      .run        (cell_run[g]),
      .gt         (cell_gt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_valid_r <= pop_ok;
      freq_r       <= pop_ok ? cell_freq[0] : '0;
      tag_r        <= pop_ok ? cell_tag[0] : '0;
      occ_r        <= OCC_W'(count_nxt);
      empty_r      <= count_nxt == '0;
      status_r     <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item_valid = item_valid_r;
  assign out_freq       = freq_r;
  assign out_tag        = tag_r;
  assign out_occupancy  = occ_r;
  assign out_is_empty   = empty_r;
  assign out_status     = status_r;

`include "assert_macros.svh"

  `SPL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `SPL_ASSERT_NEXT(a_pop_shrinks, accept && (in_kind == KIND_POP) && !empty,
                   count_r == $past(count_r) - 1'b1)
  `SPL_ASSERT_NOW(a_item_ok, out_valid_r && item_valid_r, status_r == ST_OK)
  `SPL_ASSERT_NOW(a_empty_match, out_valid_r && (CNT_W == OCC_W),
                  empty_r == (occ_r == '0))

endmodule

// ===== tb/sv/sorted_priority_list_checker.sv =====
`timescale 1ns / 100ps

module sorted_priority_list_checker
  import spl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [FREQ_W-1:0] in_new_freq,
  input  logic [TAG_W-1:0]  in_new_tag,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_item_valid,
  input  logic [FREQ_W-1:0] out_freq,
  input  logic [TAG_W-1:0]  out_tag,
  input  logic [OCC_W-1:0]  out_occupancy,
  input  logic              out_is_empty,
  input  logic [1:0]        out_status,
  output int                fail_count,
  output int                results_owed
);

  typedef struct packed {
    logic              item_valid;
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
    logic [1:0]        status;
  } list_result_t;

  logic [FREQ_W-1:0] list_freq [DEPTH];
  logic [TAG_W-1:0]  list_tag  [DEPTH];
  int                list_count;
  list_result_t      awaited_results [$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
    list_count   = 0;
  end

  function automatic list_result_t apply_list_op(input logic [1:0] kind,
                                                 input logic [FREQ_W-1:0] freq,
                                                 input logic [TAG_W-1:0] tag);
    list_result_t r;
    int           pos;
    int           i;
    r        = '0;
    r.status = ST_OK;
    if (kind == KIND_SORTED || kind == KIND_APPEND) begin
      if (list_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = list_count;
        if (kind == KIND_SORTED) begin
          pos = 0;
          while (pos < list_count && list_freq[pos] > freq) pos++;
        end
        for (i = list_count; i > pos; i--) begin
          list_freq[i] = list_freq[i-1];
          list_tag[i]  = list_tag[i-1];
        end
        list_freq[pos] = freq;
        list_tag[pos]  = tag;
        list_count++;
      end
    end else if (kind == KIND_POP) begin
      if (list_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        list_count--;
        r.item_valid = 1'b1;
        r.freq       = list_freq[list_count];
        r.tag        = list_tag[list_count];
      end
    end
    r.occupancy = list_count[OCC_W-1:0];
    r.is_empty  = (list_count == 0);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("item_valid", want.item_valid, out_item_valid);
          check_field("freq", want.freq, out_freq);
          check_field("tag", want.tag, out_tag);
          check_field("occupancy", want.occupancy, out_occupancy);
          check_field("is_empty", want.is_empty, out_is_empty);
          check_field("status", want.status, out_status);
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(apply_list_op(in_kind, in_new_freq, in_new_tag));
    end
    results_owed = awaited_results.size();
  end

endmodule

// ===== tb/sv/sorted_priority_list_core_tb.sv =====
`timescale 1ns / 100ps

module sorted_priority_list_core_tb;
  import spl_pkg::*;

  localparam logic [1:0] KIND_IDLE      = 2'd3;
  localparam int         TOTAL_REQS     = 1550;
  localparam int         RX_HOLD_CYCLES = 150;
  localparam int         CYCLE_LIMIT    = 250000;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind        = '0;
  logic [FREQ_W-1:0] in_new_freq    = '0;
  logic [TAG_W-1:0]  in_new_tag     = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_item_valid;
  logic [FREQ_W-1:0] out_freq;
  logic [TAG_W-1:0]  out_tag;
  logic [OCC_W-1:0]  out_occupancy;
  logic              out_is_empty;
  logic [1:0]        out_status;

  int fail_count;
  int results_owed;
  int cycle_count     = 0;
  int hold_asked      = 0;
  int hold_served     = 0;
  int rx_hold_left    = 0;
  int rx_gap_left     = 0;
  int rx_stretch_left = 0;
  bit rx_idle_on      = 1'b1;
  int tx_stretch_left = 0;
  bit tx_idle_on      = 1'b1;
  bit calm            = 1'b0;
  int sent            = 0;

  always #6 clk = ~clk;

  sorted_priority_list_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_new_freq   (in_new_freq),
    .in_new_tag    (in_new_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item_valid(out_item_valid),
    .out_freq      (out_freq),
    .out_tag       (out_tag),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status)
  );

  sorted_priority_list_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_new_freq   (in_new_freq),
    .in_new_tag    (in_new_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item_valid(out_item_valid),
    .out_freq      (out_freq),
    .out_tag       (out_tag),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_list_core regression: fail");
      $finish;
    end
  end

  // random stall bursts, one long hold when asked, none once calm
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served  <= hold_asked;
      rx_hold_left <= RX_HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (rx_gap_left > 0) begin
      out_ready   <= 1'b0;
      rx_gap_left <= rx_gap_left - 1;
    end else begin
      if (rx_stretch_left == 0) begin
        rx_stretch_left <= $urandom_range(16, 160);
        rx_idle_on      <= ($urandom_range(0, 9) < 7);
      end else begin
        rx_stretch_left <= rx_stretch_left - 1;
      end
      if (rx_idle_on && !calm && $urandom_range(0, 99) < 25) begin
        out_ready   <= 1'b0;
        rx_gap_left <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [FREQ_W-1:0] freq,
                          input logic [TAG_W-1:0] tag);
    int gap;
    if (tx_stretch_left == 0) begin
      tx_stretch_left = $urandom_range(16, 160);
      tx_idle_on      = ($urandom_range(0, 9) < 7);
    end else begin
      tx_stretch_left--;
    end
    @(negedge clk);
    if (tx_idle_on && !calm && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_new_freq <= freq;
    in_new_tag  <= tag;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_owed == 0);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq(input bit ties);
    if (ties) return FREQ_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return FREQ_W'($urandom_range(0, 15));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  initial begin
    int         mode;
    int         seg_len;
    int         j;
    int         push_pct;
    int         roll;
    logic [1:0] kind;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(KIND_POP, 24'h0, 9'h0);
    send_req(KIND_IDLE, '1, '1);
    send_req(KIND_SORTED, '1, '1);
    send_req(KIND_SORTED, '0, '0);
    send_req(KIND_SORTED, 24'd100, 9'd1);
    send_req(KIND_SORTED, 24'd100, 9'd2);
    send_req(KIND_SORTED, 24'd100, 9'd3);
    send_req(KIND_APPEND, '1, 9'h155);
    send_req(KIND_SORTED, 24'd50, 9'h0AA);
    send_req(KIND_IDLE, 24'h123456, 9'h0F0);
    repeat (8) send_req(KIND_POP, 24'hABCDEF, 9'h1FF);
    send_req(KIND_APPEND, '0, '0);
    send_req(KIND_SORTED, 24'h800000, 9'h100);
    send_req(KIND_POP, '0, '0);
    send_req(KIND_POP, '0, '0);

    while (sent < TOTAL_REQS) begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(40, 140);
      case (mode)
        0:       push_pct = 90;
        1:       push_pct = 10;
        2:       push_pct = 50;
        default: push_pct = 60;
      endcase
      for (j = 0; j < seg_len && sent < TOTAL_REQS; j++) begin
        if (sent == 400) hold_asked++;
        if (sent == 800) drain_all();
        if (sent >= TOTAL_REQS - 200) calm = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3) kind = KIND_IDLE;
        else if ($urandom_range(0, 99) < push_pct)
          kind = ($urandom_range(0, 9) < 7) ? KIND_SORTED : KIND_APPEND;
        else kind = KIND_POP;
        send_req(kind, pick_freq(mode == 3), TAG_W'($urandom));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("sorted_priority_list_core regression: pass");
    else
      $display("sorted_priority_list_core regression: fail");
    $finish;
  end

endmodule

// ===== sorted_priority_list_core.f =====
+incdir+src
src/spl_pkg.sv
src/spl_cell.sv
src/sorted_priority_list_core.sv
tb/sv/sorted_priority_list_checker.sv
tb/sv/sorted_priority_list_core_tb.sv
